>>> rtl/generational_subscription_table_defines.svh
// ----------------------------------------------------------------------------
// generational_subscription_table_defines.svh
// Assertion macros for the subscription table RTL.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_SUBSCRIPTION_TABLE_DEFINES_SVH
`define GENERATIONAL_SUBSCRIPTION_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled in reset
`define GST_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled in reset
`define GST_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define GST_ASSERT_IMPL(lbl, ante, cons, msg)
`define GST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/gst_pkg.sv
// ----------------------------------------------------------------------------
// gst_pkg
// Types and constants of the generational subscription table.
// ----------------------------------------------------------------------------
package gst_pkg;

   localparam int NUM_SLOTS_DEF = 32;
   localparam int MAX_RESULTS   = 32;
   localparam int GEN_W         = 24;
   localparam int TYPE_W        = 8;
   localparam int TAG_W         = 16;
   localparam int SLOT_FIELD_W  = 8;
   localparam int HANDLE_W      = 32;
   localparam int STATUS_W      = 2;
   localparam int MODE_W        = 2;
   localparam int ENTRY_W       = GEN_W + TYPE_W + TAG_W;
   localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

   localparam logic [GEN_W-1:0] GEN_LIMIT = 24'hFFFFFF;
   localparam logic [GEN_W-1:0] GEN_WRAP  = 24'd1;

   typedef enum logic [MODE_W-1:0] {
      MODE_SUB   = 2'd0,
      MODE_UNSUB = 2'd1,
      MODE_PUB   = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 2'd0,
      STAT_BAD_HANDLE = 2'd1,
      STAT_NO_SLOT    = 2'd2,
      STAT_NO_HANDLER = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SUB_SCAN,
      ST_UNS_CHECK,
      ST_PUB_SCAN,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_NEXT,
      RD_HANDLE
   } rd_sel_type;

   typedef enum logic [2:0] {
      PK_SUB_OK,
      PK_SUB_FULL,
      PK_NO_HANDLER,
      PK_BAD_HANDLE,
      PK_UNS_OK,
      PK_PUB_MATCH
   } pend_kind_type;

   typedef struct packed {
      logic          req_ready;
      logic          idx_inc;
      rd_sel_type    rd_sel;
      logic          mem_wr;
      logic          act_set;
      logic          act_clr;
      logic          gen_bump;
      logic          pend_load;
      pend_kind_type pend_kind;
      logic          pend_push;
      logic          push_last;
   } cmd_type;

   typedef struct packed {
      logic     req_valid;
      mode_type mode;
      logic     hpres;
      logic     handle_ok;
      logic     slot_free;
      logic     idx_last;
      logic     uns_hit;
      logic     pub_match;
      logic     out_free;
      logic     pend_valid;
   } stat_type;

endpackage

>>> rtl/generational_subscription_table.sv
// ----------------------------------------------------------------------------
// generational_subscription_table
// Slot table with generation-tagged handles: subscribe, unsubscribe, publish.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one request per handshake; tuser carries the mode
//    (subscribe, unsubscribe, publish), tdata the operands.
//  - rsp channel: subscribe and unsubscribe give one response each; publish
//    gives one response per matching slot in slot order, none if no match.
//    tlast marks the final response of a request.
//  - Requests are handled one at a time; req_tready is high only between
//    requests. Subscribe scans the active bits one slot per cycle up to the
//    first free slot or the last slot, unsubscribe checks only the slot its
//    handle names, publish walks every slot once through the slot memory
//    read port.
//  - A response sits in an output register; while rsp_tready is low the
//    scan holds on its next match and the register keeps its response.
//  - Synchronous reset clears all active bits and the generation counter;
//    the slot memory is not cleared, it is only read for active slots.
// ----------------------------------------------------------------------------
`include "generational_subscription_table_defines.svh"

module generational_subscription_table
   import gst_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata, low bit up: event_type[7:0], handler_present[8],
   // subscriber_tag[24:9], handle[56:25], zero fill[63:57]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,   // mode
   // rsp_tdata, low bit up: result_handle[31:0], result_slot[39:32],
   // result_tag[55:40]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // status
   output logic        rsp_tlast    // last
);

   cmd_type  cmd;
   stat_type st;

   gst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   gst_dpath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .st         (st)
   );

   // a new request must never find a response still held back
   `GST_ASSERT_IMPL(a_accept_no_pend, req_tvalid && req_tready, !st.pend_valid, "pend at accept")
   // the held response only moves into a free output register
   `GST_ASSERT_IMPL(a_push_safe, cmd.pend_push, st.out_free && st.pend_valid, "push while busy")
   // only a free slot is ever written
   `GST_ASSERT_IMPL(a_write_free, cmd.mem_wr, st.slot_free && cmd.act_set, "write to active slot")
   // one request at a time
   `GST_ASSERT_NEXT(a_single_req, req_tvalid && req_tready, !req_tready, "back to back accept")

endmodule

>>> rtl/gst_ctrl.sv
// ----------------------------------------------------------------------------
// gst_ctrl
// Sequencer: dispatches a request and steps the slot scans.
// ----------------------------------------------------------------------------
module gst_ctrl
   import gst_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type st,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      pub_stall;

   assign pub_stall = st.pub_match && st.pend_valid && !st.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (st.req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (st.mode)
               MODE_SUB:   state_in = st.hpres ? ST_SUB_SCAN : ST_FLUSH;
               MODE_UNSUB: state_in = st.handle_ok ? ST_UNS_CHECK : ST_FLUSH;
               MODE_PUB:   state_in = ST_PUB_SCAN;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_SUB_SCAN: begin
            if (st.slot_free || st.idx_last) state_in = ST_FLUSH;
         end
         ST_UNS_CHECK: begin
            state_in = ST_FLUSH;
         end
         ST_PUB_SCAN: begin
            if (!pub_stall && st.idx_last) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (!st.pend_valid || st.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.rd_sel    = RD_IDX;
      cmd.pend_kind = PK_PUB_MATCH;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
         end
         ST_DISPATCH: begin
            unique case (st.mode)
               MODE_SUB: begin
                  if (!st.hpres) begin
                     cmd.pend_load = 1'b1;
                     cmd.pend_kind = PK_NO_HANDLER;
                  end
               end
               MODE_UNSUB: begin
                  if (st.handle_ok) begin
                     cmd.rd_sel = RD_HANDLE;
                  end else begin
                     cmd.pend_load = 1'b1;
                     cmd.pend_kind = PK_BAD_HANDLE;
                  end
               end
               default: ;
            endcase
         end
         ST_SUB_SCAN: begin
            if (st.slot_free) begin
               cmd.mem_wr    = 1'b1;
               cmd.act_set   = 1'b1;
               cmd.gen_bump  = 1'b1;
               cmd.pend_load = 1'b1;
               cmd.pend_kind = PK_SUB_OK;
            end else if (st.idx_last) begin
               cmd.pend_load = 1'b1;
               cmd.pend_kind = PK_SUB_FULL;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_UNS_CHECK: begin
            cmd.pend_load = 1'b1;
            if (st.uns_hit) begin
               cmd.act_clr   = 1'b1;
               cmd.pend_kind = PK_UNS_OK;
            end else begin
               cmd.pend_kind = PK_BAD_HANDLE;
            end
         end
         ST_PUB_SCAN: begin
            if (!pub_stall) begin
               if (st.pub_match) begin
                  cmd.pend_load = 1'b1;
                  cmd.pend_kind = PK_PUB_MATCH;
                  cmd.pend_push = st.pend_valid;
               end
               if (!st.idx_last) begin
                  cmd.idx_inc = 1'b1;
                  cmd.rd_sel  = RD_NEXT;
               end
            end
         end
         ST_FLUSH: begin
            if (st.pend_valid && st.out_free) begin
               cmd.pend_push = 1'b1;
               cmd.push_last = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

>>> rtl/gst_dpath.sv
// ----------------------------------------------------------------------------
// gst_dpath
// Slot store, generation counter, hold stage and response register.
// ----------------------------------------------------------------------------
module gst_dpath
   import gst_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  cmd_type     cmd,
   output stat_type    st
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // captured request
   logic [MODE_W-1:0]   mode_ff;
   logic [TYPE_W-1:0]   type_ff;
   logic                hpres_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic [HANDLE_W-1:0] handle_ff;

   logic [IDX_W-1:0]     idx_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [NUM_SLOTS-1:0] active_ff;
   logic [GEN_W-1:0]     gen_ff;

   logic [ENTRY_W-1:0] mem [NUM_SLOTS];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;

   // hold stage: one result waits here until it is known whether it is last
   logic                    pend_valid_ff;
   logic [STATUS_W-1:0]     pend_status_ff, pend_status_in;
   logic [HANDLE_W-1:0]     pend_handle_ff, pend_handle_in;
   logic [SLOT_FIELD_W-1:0] pend_slot_ff, pend_slot_in;
   logic [TAG_W-1:0]        pend_tag_ff, pend_tag_in;

   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [HANDLE_W-1:0]     rsp_handle_ff;
   logic [SLOT_FIELD_W-1:0] rsp_slot_ff;
   logic [TAG_W-1:0]        rsp_tag_ff;
   logic                    rsp_last_ff;

   logic                    accept;
   logic [SLOT_FIELD_W-1:0] sbits;
   logic [IDX_W-1:0]        slot_s;
   logic [GEN_W-1:0]        gen_use, gen_next;
   logic [GEN_W-1:0]        rd_gen;
   logic [TYPE_W-1:0]       rd_type;
   logic [TAG_W-1:0]        rd_tag;
   logic [SLOT_FIELD_W-1:0] idx8, idx_plus1;

   assign req_tready = cmd.req_ready;
   assign accept     = req_tvalid && req_tready;

   assign sbits     = handle_ff[SLOT_FIELD_W-1:0];
   assign slot_s    = IDX_W'(sbits - SLOT_FIELD_W'(1));
   assign {rd_gen, rd_type, rd_tag} = rd_data_ff;
   assign idx8      = SLOT_FIELD_W'(idx_ff);
   assign idx_plus1 = idx8 + SLOT_FIELD_W'(1);

   // counter value 0xFFFFFF is never handed out: it and the next one both become 1
   assign gen_use  = (gen_ff == GEN_LIMIT) ? GEN_WRAP : gen_ff;
   assign gen_next = (gen_ff == GEN_LIMIT) ? GEN_WRAP : gen_ff + GEN_W'(1);

   always_comb begin
      st            = '0;
      st.req_valid  = req_tvalid;
      st.mode       = mode_type'(mode_ff);
      st.hpres      = hpres_ff;
      st.handle_ok  = (sbits != '0) && (sbits <= SLOT_FIELD_W'(NUM_SLOTS));
      st.slot_free  = !active_ff[idx_ff];
      st.idx_last   = (idx_ff == IDX_W'(NUM_SLOTS - 1));
      st.uns_hit    = active_ff[slot_s] && (rd_gen == handle_ff[HANDLE_W-1:SLOT_FIELD_W]);
      st.pub_match  = active_ff[idx_ff] && (rd_type == type_ff)
                      && (cnt_ff < CNT_W'(MAX_RESULTS));
      st.out_free   = !rsp_valid_ff || rsp_tready;
      st.pend_valid = pend_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_tuser;
         type_ff   <= req_tdata[7:0];
         hpres_ff  <= req_tdata[8];
         tag_ff    <= req_tdata[24:9];
         handle_ff <= req_tdata[56:25];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         cnt_ff    <= '0;
         active_ff <= '0;
         gen_ff    <= '0;
      end else begin
         if (accept) begin
            idx_ff <= '0;
            cnt_ff <= '0;
         end else begin
            if (cmd.idx_inc) idx_ff <= idx_ff + IDX_W'(1);
            if (cmd.pend_load && cmd.pend_kind == PK_PUB_MATCH) begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
         end
         if (cmd.act_set) active_ff[idx_ff] <= 1'b1;
         if (cmd.act_clr) active_ff[slot_s] <= 1'b0;
         if (cmd.gen_bump) gen_ff <= gen_next;
      end
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RD_IDX:    rd_addr = idx_ff;
         RD_NEXT:   rd_addr = idx_ff + IDX_W'(1);
         RD_HANDLE: rd_addr = slot_s;
         default:   rd_addr = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) mem[idx_ff] <= {gen_use, type_ff, tag_ff};
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      pend_status_in = STAT_OK;
      pend_handle_in = '0;
      pend_slot_in   = '0;
      pend_tag_in    = '0;
      unique case (cmd.pend_kind)
         PK_SUB_OK: begin
            pend_handle_in = {gen_use, idx_plus1};
            pend_slot_in   = idx8;
         end
         PK_SUB_FULL:   pend_status_in = STAT_NO_SLOT;
         PK_NO_HANDLER: pend_status_in = STAT_NO_HANDLER;
         PK_BAD_HANDLE: pend_status_in = STAT_BAD_HANDLE;
         PK_UNS_OK:     pend_slot_in   = SLOT_FIELD_W'(slot_s);
         PK_PUB_MATCH: begin
            pend_handle_in = {rd_gen, idx_plus1};
            pend_slot_in   = idx8;
            pend_tag_in    = rd_tag;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.pend_load)      pend_valid_ff <= 1'b1;
         else if (cmd.pend_push) pend_valid_ff <= 1'b0;
         if (cmd.pend_push)      rsp_valid_ff  <= 1'b1;
         else if (rsp_tready)    rsp_valid_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pend_load) begin
         pend_status_ff <= pend_status_in;
         pend_handle_ff <= pend_handle_in;
         pend_slot_ff   <= pend_slot_in;
         pend_tag_ff    <= pend_tag_in;
      end
      if (cmd.pend_push) begin
         rsp_status_ff <= pend_status_ff;
         rsp_handle_ff <= pend_handle_ff;
         rsp_slot_ff   <= pend_slot_ff;
         rsp_tag_ff    <= pend_tag_ff;
         rsp_last_ff   <= cmd.push_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_tag_ff, rsp_slot_ff, rsp_handle_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
